[rtl/adtd_pkg.sv]
`default_nettype none

package adtd_pkg;

    // Reciprocal of 100 scaled by 2**19. It is exact for every year below 16384.
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam logic [6:0]  CENTURY     = 7'd100;
    localparam logic [6:0]  LAST_IN_CENTURY = 7'd99;
    localparam logic [13:0] YEAR_MAX    = 14'd16383;
    localparam logic [3:0]  LAST_MONTH  = 4'd12;
    localparam logic [3:0]  FIRST_MONTH = 4'd1;
    localparam logic [8:0]  DAYS_LEAP   = 9'd366;
    localparam logic [8:0]  DAYS_COMMON = 9'd365;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECIP,
        S_REM,
        S_CHECK,
        S_MSUM,
        S_ADD,
        S_YEAR,
        S_MONTH,
        S_DONE
    } state_t;

    // Length of a month, given as 1..12, in a leap or common year.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month) inside
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? DAYS_LEAP : DAYS_COMMON;
    endfunction

endpackage

`default_nettype wire

[rtl/add_days_to_date.sv]
// Steps: reciprocal product, year remainder, date check, sum of the start months,
// add, year walk, month walk, result; a malformed date goes from the check to the result.
// The year walk dominates the latency.
// Throughput: one item at a time; the next input is taken once the result is in the
// output register, so the output stage overlaps with the next item's work.
// Reset: rst_n clears the sequencer and the output valid flag asynchronously.
`default_nettype none

module add_days_to_date
    import adtd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [4:0]  start_day,
    input  wire logic [3:0]  start_month,
    input  wire logic [13:0] start_year,
    input  wire logic [14:0] days_to_add,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       end_day,
    output logic [3:0]       end_month,
    output logic [13:0]      end_year,
    output logic             bad_input
);

    // Sequencer state and the working registers of the item in flight.
    state_t      state_reg, state_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [14:0] year_reg, year_next;
    logic [14:0] add_reg, add_next;
    logic [26:0] prod_reg, prod_next;
    logic [6:0]  yrem_reg, yrem_next;   // year modulo 100
    logic [1:0]  ycent_reg, ycent_next; // year divided by 100, modulo 4
    logic [15:0] total_reg, total_next;
    logic [3:0]  mcnt_reg, mcnt_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [4:0]  end_day_reg, end_day_next;
    logic [3:0]  end_month_reg, end_month_next;
    logic [13:0] end_year_reg, end_year_next;
    logic        end_bad_reg, end_bad_next;
    logic        bad_reg, bad_next;

    // Shared add/subtract unit. It also yields the "total is greater" compare.
    logic [15:0] alu_b;
    logic        alu_sub;
    logic [16:0] alu_res;
    logic        alu_gt;

    logic        in_xfer;
    logic        out_free;
    logic        leap;
    logic [7:0]  quo;
    logic [14:0] quo_x100;
    logic [14:0] rem_full;
    logic [4:0]  start_mlen;
    logic        date_bad;
    logic        year_over;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // The block takes a new item only while the sequencer is idle.
    assign in_stall = (state_reg != S_IDLE);

    // A year is a leap year when it is divisible by 4 and not by 100, or by 400.
    // Once year mod 100 is zero the year is already a multiple of 4.
    assign leap = (yrem_reg == 7'd0) ? (ycent_reg == 2'd0) : (year_reg[1:0] == 2'b00);

    assign quo      = prod_reg[26:RECIP_SHIFT];
    assign quo_x100 = 15'(quo) * 15'(CENTURY);
    assign rem_full = year_reg - quo_x100;

    assign start_mlen = month_len(month_reg, leap);
    assign date_bad   = (month_reg < FIRST_MONTH) || (month_reg > LAST_MONTH)
                      || (day_reg == 5'd0) || (day_reg > start_mlen);

    assign year_over = (year_reg > 15'(YEAR_MAX));

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_b   = 16'd0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_MSUM:  alu_b = 16'(month_len(mcnt_reg, leap));
            S_ADD:   alu_b = 16'(add_reg);
            S_YEAR:
            begin
                alu_b   = 16'(year_len(leap));
                alu_sub = 1'b1;
            end
            S_MONTH:
            begin
                alu_b   = 16'(month_len(mcnt_reg, leap));
                alu_sub = 1'b1;
            end
            default: alu_b = 16'd0;
        endcase
    end

    assign alu_res = alu_sub ? ({1'b0, total_reg} - {1'b0, alu_b})
                             : ({1'b0, total_reg} + {1'b0, alu_b});
    // Total exceeds the operand when the difference neither borrows nor is zero.
    assign alu_gt  = !alu_res[16] && (alu_res[15:0] != 16'd0);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_RECIP;
            S_RECIP: state_next = S_REM;
            S_REM:   state_next = S_CHECK;
            S_CHECK: state_next = date_bad ? S_DONE : S_MSUM;
            S_MSUM:  if (mcnt_reg == month_reg) state_next = S_ADD;
            S_ADD:   state_next = S_YEAR;
            S_YEAR:  if (!alu_gt) state_next = S_MONTH;
            S_MONTH: if (mcnt_reg == LAST_MONTH || !alu_gt) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output-register updates.
    always_comb
    begin
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        add_next       = add_reg;
        prod_next      = prod_reg;
        yrem_next      = yrem_reg;
        ycent_next     = ycent_reg;
        total_next     = total_reg;
        mcnt_next      = mcnt_reg;
        bad_next       = bad_reg;
        end_day_next   = end_day_reg;
        end_month_next = end_month_reg;
        end_year_next  = end_year_reg;
        end_bad_next   = end_bad_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    day_next   = start_day;
                    month_next = start_month;
                    year_next  = 15'(start_year);
                    add_next   = days_to_add;
                end
            end
            S_RECIP:
            begin
                prod_next = 27'(year_reg) * 27'(RECIP_100);
            end
            S_REM:
            begin
                yrem_next  = rem_full[6:0];
                ycent_next = quo[1:0];
            end
            S_CHECK:
            begin
                bad_next   = date_bad;
                total_next = 16'(day_reg);
                mcnt_next  = FIRST_MONTH;
            end
            S_MSUM:
            begin
                if (mcnt_reg != month_reg)
                begin
                    total_next = alu_res[15:0];
                    mcnt_next  = mcnt_reg + 4'd1;
                end
            end
            S_ADD:
            begin
                total_next = alu_res[15:0];
                mcnt_next  = FIRST_MONTH;
            end
            S_YEAR:
            begin
                if (alu_gt)
                begin
                    total_next = alu_res[15:0];
                    year_next  = year_reg + 15'd1;
                    if (yrem_reg == LAST_IN_CENTURY)
                    begin
                        yrem_next  = 7'd0;
                        ycent_next = ycent_reg + 2'd1;
                    end
                    else
                    begin
                        yrem_next = yrem_reg + 7'd1;
                    end
                end
            end
            S_MONTH:
            begin
                if (mcnt_reg != LAST_MONTH && alu_gt)
                begin
                    total_next = alu_res[15:0];
                    mcnt_next  = mcnt_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    end_bad_next   = bad_reg;
                    if (bad_reg)
                    begin
                        end_day_next   = 5'd0;
                        end_month_next = 4'd0;
                        end_year_next  = 14'd0;
                    end
                    else
                    begin
                        end_day_next   = total_reg[4:0];
                        end_month_next = mcnt_reg;
                        end_year_next  = year_over ? YEAR_MAX : year_reg[13:0];
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg       <= day_next;
        month_reg     <= month_next;
        year_reg      <= year_next;
        add_reg       <= add_next;
        prod_reg      <= prod_next;
        yrem_reg      <= yrem_next;
        ycent_reg     <= ycent_next;
        total_reg     <= total_next;
        mcnt_reg      <= mcnt_next;
        bad_reg       <= bad_next;
        end_day_reg   <= end_day_next;
        end_month_reg <= end_month_next;
        end_year_reg  <= end_year_next;
        end_bad_reg   <= end_bad_next;
    end

    assign out_valid = out_valid_reg;
    assign end_day   = end_day_reg;
    assign end_month = end_month_reg;
    assign end_year  = end_year_reg;
    assign bad_input = end_bad_reg;

`ifndef SYNTHESIS
    // A flagged result carries an all-zero date.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_input) |-> (end_day == 5'd0 && end_month == 4'd0
                                      && end_year == 14'd0))
        else $error("flagged result carries a nonzero date");

    // A good result always names a real month and a nonzero day.
    a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_input) |-> (end_day != 5'd0 && end_month >= FIRST_MONTH
                                       && end_month <= LAST_MONTH))
        else $error("result date out of range");

    // The tracked year remainder stays a true remainder while years are walked.
    a_yrem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR || state_reg == S_MONTH) |-> (yrem_reg < CENTURY))
        else $error("year remainder out of range");

    // An input transfer always starts the reciprocal step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_RECIP))
        else $error("input transfer did not start the sequencer");
`endif

endmodule

`default_nettype wire
